// ----- sv/lzbd_pkg.sv -----
`default_nettype none

package lzbd_pkg;

   // History depth and the widths that follow from it.
   localparam int HISTORY_BYTES = 16384;
   localparam int HIST_AW       = $clog2(HISTORY_BYTES);
   localparam int CNT_W         = $clog2(HISTORY_BYTES + 1);
   localparam int SUM_W         = HIST_AW + 1;

   // Widths fixed by the token format.
   localparam int LEN_W         = 11;
   localparam int DIST_W        = 14;
   localparam int FLAG_W        = 9;
   localparam int LANE_BYTES    = 32;
   localparam int POS_W         = $clog2(LANE_BYTES);
   localparam int COUNT_W       = POS_W + 1;
   localparam int LANE_W        = LANE_BYTES * 8;

   // Flag register value that means a flag byte comes next.
   localparam logic [FLAG_W-1:0] FLAG_EMPTY = FLAG_W'(1);

   // Token parser and copy sequencer states.
   typedef enum logic [1:0] {
      ST_TOKEN = 2'b01,
      ST_COPY  = 2'b10
   } state_type;

   // One packed result on its way to the output register.
   typedef struct packed {
      logic [LANE_W-1:0]  lanes;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               bad;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/lzbd_hist_ram.sv -----
`default_nettype none

module lzbd_hist_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [lzbd_pkg::HIST_AW-1:0] wr_addr,
   input  wire logic [7:0]                  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [lzbd_pkg::HIST_AW-1:0] rd_addr,
   output logic      [7:0]                  rd_data
);

   logic [7:0] mem [lzbd_pkg::HISTORY_BYTES];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/lzbd_engine.sv -----
`default_nettype none

module lzbd_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_block_start,
   output lzbd_pkg::result_type    res,
   output logic                    res_full,
   input  wire logic               res_take
);

   lzbd_pkg::state_type state_ff, state_in;

   logic [lzbd_pkg::FLAG_W-1:0]  flag_ff, flag_in;
   logic [7:0]                   high_ff, high_in;
   logic                         pend_ff, pend_in;
   logic [lzbd_pkg::HIST_AW-1:0] wp_ff, wp_in;
   logic [lzbd_pkg::CNT_W-1:0]   prod_ff, prod_in;
   logic [lzbd_pkg::LEN_W-1:0]   remain_ff, remain_in;
   logic [lzbd_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [lzbd_pkg::POS_W-1:0]   pos_ff, pos_in;

   // Read stage: the byte whose history read is in flight.
   logic                         p_valid_ff, p_valid_in;
   logic                         p_bad_ff, p_bad_in;
   logic                         p_end_ff, p_end_in;
   logic                         p_last_ff, p_last_in;
   logic [lzbd_pkg::POS_W-1:0]   p_pos_ff, p_pos_in;
   logic [lzbd_pkg::HIST_AW-1:0] p_wp_ff, p_wp_in;

   lzbd_pkg::result_type         asm_ff, asm_in;
   logic                         asm_full_ff, asm_full_in;

   logic                         busy, accept, do_issue, is_literal;
   logic [lzbd_pkg::FLAG_W-1:0]  flag_eff, flag_shifted;
   logic                         pend_eff;
   logic [lzbd_pkg::CNT_W-1:0]   prod_base, prod_next;
   logic [lzbd_pkg::HIST_AW-1:0] wp_next;
   logic [15:0]                  ref_word;
   logic [lzbd_pkg::LEN_W-1:0]   ref_len;
   logic [lzbd_pkg::DIST_W-1:0]  ref_dist;
   logic [lzbd_pkg::SUM_W-1:0]   src_sum;
   logic [lzbd_pkg::HIST_AW-1:0] src_addr;
   logic                         src_bad;
   logic [7:0]                   rd_data, p_byte;
   logic                         wr_en;
   logic [lzbd_pkg::HIST_AW-1:0] wr_addr;
   logic [7:0]                   wr_data;

   // The parser takes a request only when no copy or packed result is pending.
   assign busy      = (state_ff == lzbd_pkg::ST_COPY) || p_valid_ff || asm_full_ff;
   assign accept    = req_valid && !busy;
   assign req_stall = busy;

   // A block start resets the token state for this request.
   assign flag_eff  = req_block_start ? lzbd_pkg::FLAG_EMPTY : flag_ff;
   assign pend_eff  = req_block_start ? 1'b0 : pend_ff;
   assign prod_base = (accept && req_block_start) ? '0 : prod_ff;

   assign is_literal = accept && !pend_eff && (flag_eff > lzbd_pkg::FLAG_EMPTY) &&
                       !flag_eff[0];
   assign flag_shifted = ((flag_eff >> 1) == '0) ? lzbd_pkg::FLAG_EMPTY : (flag_eff >> 1);

   // Decode the reference word into length and distance.
   assign ref_word = {high_ff, req_in_byte};
   always_comb begin
      if (ref_word[15]) begin
         ref_len  = lzbd_pkg::LEN_W'(ref_word[14:5]) + lzbd_pkg::LEN_W'(3);
         ref_dist = {lzbd_pkg::DIST_W'(ref_word[4:0]) + lzbd_pkg::DIST_W'(1)} << 2;
      end else begin
         ref_len  = lzbd_pkg::LEN_W'(ref_word[15:11]) + lzbd_pkg::LEN_W'(3);
         ref_dist = {lzbd_pkg::DIST_W'(ref_word[10:0]) + lzbd_pkg::DIST_W'(33)} << 2;
      end
   end

   // The next copy byte may issue once the previous chunk has left the packer.
   assign do_issue = (state_ff == lzbd_pkg::ST_COPY) && !asm_full_ff &&
                     !(p_valid_ff && p_end_ff);

   // Source address wraps around the history; distance never exceeds its depth.
   assign src_sum = lzbd_pkg::SUM_W'(wp_ff) + lzbd_pkg::SUM_W'(lzbd_pkg::HISTORY_BYTES) -
                    lzbd_pkg::SUM_W'(dist_ff);
   assign src_addr = (src_sum >= lzbd_pkg::SUM_W'(lzbd_pkg::HISTORY_BYTES)) ?
                     lzbd_pkg::HIST_AW'(src_sum - lzbd_pkg::SUM_W'(lzbd_pkg::HISTORY_BYTES)) :
                     lzbd_pkg::HIST_AW'(src_sum);
   assign src_bad  = (lzbd_pkg::CNT_W'(dist_ff) > prod_ff) ||
                     (lzbd_pkg::DIST_W > lzbd_pkg::CNT_W &&
                      (dist_ff >> lzbd_pkg::CNT_W) != '0);

   // Write pointer and produced count step once per output byte.
   always_comb begin
      if (wp_ff == lzbd_pkg::HIST_AW'(lzbd_pkg::HISTORY_BYTES - 1)) begin
         wp_next = '0;
      end else begin
         wp_next = wp_ff + lzbd_pkg::HIST_AW'(1);
      end
   end
   assign prod_next = (prod_base < lzbd_pkg::CNT_W'(lzbd_pkg::HISTORY_BYTES)) ?
                      prod_base + lzbd_pkg::CNT_W'(1) : prod_base;

   assign p_byte = p_bad_ff ? 8'h00 : rd_data;

   // History writes come from a literal or from the read stage of a copy.
   always_comb begin
      if (is_literal) begin
         wr_en   = 1'b1;
         wr_addr = wp_ff;
         wr_data = req_in_byte;
      end else begin
         wr_en   = p_valid_ff;
         wr_addr = p_wp_ff;
         wr_data = p_byte;
      end
   end

   lzbd_hist_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (do_issue),
      .rd_addr (src_addr),
      .rd_data (rd_data)
   );

   // Token parsing, copy sequencing and result packing.
   always_comb begin
      state_in    = state_ff;
      flag_in     = flag_ff;
      high_in     = high_ff;
      pend_in     = pend_ff;
      wp_in       = wp_ff;
      prod_in     = prod_ff;
      remain_in   = remain_ff;
      dist_in     = dist_ff;
      pos_in      = pos_ff;
      p_valid_in  = 1'b0;
      p_bad_in    = p_bad_ff;
      p_end_in    = p_end_ff;
      p_last_in   = p_last_ff;
      p_pos_in    = p_pos_ff;
      p_wp_in     = p_wp_ff;
      asm_in      = asm_ff;
      asm_full_in = asm_full_ff && !res_take;

      if (accept) begin
         prod_in = prod_base;
         flag_in = flag_eff;
         pend_in = pend_eff;
         if (pend_eff) begin
            pend_in   = 1'b0;
            flag_in   = flag_shifted;
            state_in  = lzbd_pkg::ST_COPY;
            remain_in = ref_len;
            dist_in   = ref_dist;
            pos_in    = '0;
         end else if (flag_eff <= lzbd_pkg::FLAG_EMPTY) begin
            flag_in = {1'b1, req_in_byte};
         end else if (flag_eff[0]) begin
            high_in = req_in_byte;
            pend_in = 1'b1;
         end else begin
            flag_in     = flag_shifted;
            wp_in       = wp_next;
            prod_in     = prod_next;
            asm_in.lanes = lzbd_pkg::LANE_W'(req_in_byte);
            asm_in.count = lzbd_pkg::COUNT_W'(1);
            asm_in.last  = 1'b1;
            asm_in.bad   = 1'b0;
            asm_full_in  = 1'b1;
         end
      end

      if (do_issue) begin
         p_valid_in = 1'b1;
         p_bad_in   = src_bad;
         p_end_in   = (pos_ff == lzbd_pkg::POS_W'(lzbd_pkg::LANE_BYTES - 1)) ||
                      (remain_ff == lzbd_pkg::LEN_W'(1));
         p_last_in  = (remain_ff == lzbd_pkg::LEN_W'(1));
         p_pos_in   = pos_ff;
         p_wp_in    = wp_ff;
         wp_in      = wp_next;
         prod_in    = prod_next;
         pos_in     = pos_ff + lzbd_pkg::POS_W'(1);
         remain_in  = remain_ff - lzbd_pkg::LEN_W'(1);
         if (remain_ff == lzbd_pkg::LEN_W'(1)) begin
            state_in = lzbd_pkg::ST_TOKEN;
         end
      end

      if (p_valid_ff) begin
         if (p_pos_ff == '0) begin
            asm_in.lanes = lzbd_pkg::LANE_W'(p_byte);
            asm_in.bad   = p_bad_ff;
         end else begin
            asm_in.lanes[{p_pos_ff, 3'b000} +: 8] = p_byte;
            asm_in.bad   = asm_ff.bad || p_bad_ff;
         end
         asm_in.count = lzbd_pkg::COUNT_W'(p_pos_ff) + lzbd_pkg::COUNT_W'(1);
         asm_in.last  = p_last_ff;
         if (p_end_ff) begin
            asm_full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lzbd_pkg::ST_TOKEN;
         flag_ff     <= lzbd_pkg::FLAG_EMPTY;
         high_ff     <= '0;
         pend_ff     <= 1'b0;
         wp_ff       <= '0;
         prod_ff     <= '0;
         remain_ff   <= '0;
         p_valid_ff  <= 1'b0;
         asm_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         flag_ff     <= flag_in;
         high_ff     <= high_in;
         pend_ff     <= pend_in;
         wp_ff       <= wp_in;
         prod_ff     <= prod_in;
         remain_ff   <= remain_in;
         p_valid_ff  <= p_valid_in;
         asm_full_ff <= asm_full_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff   <= dist_in;
      pos_ff    <= pos_in;
      p_bad_ff  <= p_bad_in;
      p_end_ff  <= p_end_in;
      p_last_ff <= p_last_in;
      p_pos_ff  <= p_pos_in;
      p_wp_ff   <= p_wp_in;
      asm_ff    <= asm_in;
   end

   assign res      = asm_ff;
   assign res_full = asm_full_ff;

`ifndef SYNTHESIS
   // The packer never takes a byte while a finished chunk is still waiting.
   a_no_pack_when_full: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> !asm_full_ff) else $error("byte packed into a full chunk");

   // A copy in progress always has bytes left to issue.
   a_copy_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzbd_pkg::ST_COPY) |-> (remain_ff != '0))
      else $error("copy running with no bytes left");

   // An issued byte reaches the packer in the next cycle.
   a_issue_lands: assert property (@(posedge clock) disable iff (reset)
      do_issue |=> p_valid_ff) else $error("issued byte lost");

   // A finished chunk holds between one and a full lane of bytes.
   a_chunk_count: assert property (@(posedge clock) disable iff (reset)
      asm_full_ff |-> (asm_ff.count != '0) &&
                      (asm_ff.count <= lzbd_pkg::COUNT_W'(lzbd_pkg::LANE_BYTES)))
      else $error("chunk byte count out of range");
`endif

endmodule

`default_nettype wire

// ----- sv/lz_backref_decompressor_core.sv -----
// LZSS-style decompressor core.
// The request channel carries one compressed byte per request, with
// req_block_start marking the first byte of a new block. The response
// channel returns packed output bytes: up to 32 bytes per response, count in
// rsp_byte_count, rsp_last_of_run on the final response of a request and
// rsp_bad_reference when a copied byte came from before the block start.
// Flag bytes and first reference bytes give no response.
// A literal's response goes into the engine's result register and then
// moves to the output register; the next request waits for that move.
// A back-reference of length L streams one byte per cycle through the
// history memory's read port while the packer is free; each 32-byte chunk
// pauses the stream while it lands in the packer and moves out, and the
// next request is taken once the last chunk has left the packer.
// The output register lets a new request enter while a response waits.
// A stalled response holds; copying waits while the packer holds a finished
// chunk that the full output register cannot take.
// Reset (synchronous, active high) clears the token state, write pointer
// and produced count; the history memory needs no clearing pass.
`default_nettype none

module lz_backref_decompressor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_block_start,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_lane_bytes_0_7,
   output logic [63:0]      rsp_lane_bytes_8_15,
   output logic [63:0]      rsp_lane_bytes_16_23,
   output logic [63:0]      rsp_lane_bytes_24_31,
   output logic [5:0]       rsp_byte_count,
   output logic             rsp_last_of_run,
   output logic             rsp_bad_reference
);

   lzbd_pkg::result_type res;
   lzbd_pkg::result_type out_ff, out_in;
   logic                 res_full, res_take;
   logic                 out_valid_ff, out_valid_in;

   lzbd_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_block_start (req_block_start),
      .res             (res),
      .res_full        (res_full),
      .res_take        (res_take)
   );

   // Output register: loads a finished chunk when empty or being drained.
   assign res_take = res_full && (!out_valid_ff || !rsp_stall);

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (res_take) begin
         out_in       = res;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_lane_bytes_0_7   = out_ff.lanes[63:0];
   assign rsp_lane_bytes_8_15  = out_ff.lanes[127:64];
   assign rsp_lane_bytes_16_23 = out_ff.lanes[191:128];
   assign rsp_lane_bytes_24_31 = out_ff.lanes[255:192];
   assign rsp_byte_count       = out_ff.count;
   assign rsp_last_of_run      = out_ff.last;
   assign rsp_bad_reference    = out_ff.bad;

endmodule

`default_nettype wire

// ----- dv/lzbd_checker.sv -----
`default_nettype none

module lzbd_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_block_start,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_lane_bytes_0_7,
   input  wire logic [63:0] rsp_lane_bytes_8_15,
   input  wire logic [63:0] rsp_lane_bytes_16_23,
   input  wire logic [63:0] rsp_lane_bytes_24_31,
   input  wire logic [5:0]  rsp_byte_count,
   input  wire logic        rsp_last_of_run,
   input  wire logic        rsp_bad_reference,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [lzbd_pkg::LANE_W-1:0]  lanes;
      logic [lzbd_pkg::COUNT_W-1:0] count;
      logic                         last;
      logic                         bad;
   } chunk_type;

   chunk_type chunk_q[$];

   // Shadow decoder state.
   logic [7:0]                   hist_mem [lzbd_pkg::HISTORY_BYTES];
   logic [lzbd_pkg::FLAG_W-1:0]  flags;
   logic [7:0]                   hi_byte;
   logic                         hi_valid;
   logic [lzbd_pkg::HIST_AW-1:0] wr_ptr;
   int                           produced;

   assign pending_count = chunk_q.size();

   function automatic void push_hist(logic [7:0] b);
      hist_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      if (produced < lzbd_pkg::HISTORY_BYTES) produced++;
   endfunction

   // Decode one request and queue the chunks it produces.
   function automatic void decode_request(logic [7:0] b, logic blk);
      int      v, len, distance, pos;
      logic [7:0] val;
      chunk_type c;
      if (blk) begin
         flags = lzbd_pkg::FLAG_EMPTY;
         hi_valid = 1'b0;
         produced = 0;
      end
      if (hi_valid) begin
         hi_valid = 1'b0;
         v = int'({hi_byte, b});
         if (v[15]) begin
            len = ((v >> 5) & 'h3ff) + 3;
            distance = ((v & 'h1f) + 1) * 4;
         end else begin
            len = (v >> 11) + 3;
            distance = ((v & 'h7ff) + 33) * 4;
         end
         c = '0;
         for (int k = 0; k < len; k++) begin
            pos = k % lzbd_pkg::LANE_BYTES;
            if (pos == 0 && k != 0) begin
               chunk_q.push_back(c);
               c = '0;
            end
            val = 8'h00;
            if (distance > produced) c.bad = 1'b1;
            else val = hist_mem[lzbd_pkg::HIST_AW'(wr_ptr - distance)];
            c.lanes[pos*8 +: 8] = val;
            c.count = lzbd_pkg::COUNT_W'(pos + 1);
            push_hist(val);
         end
         c.last = 1'b1;
         chunk_q.push_back(c);
         flags = flags >> 1;
         if (flags == '0) flags = lzbd_pkg::FLAG_EMPTY;
      end else if (flags <= lzbd_pkg::FLAG_EMPTY) begin
         flags = {1'b1, b};
      end else if (flags[0]) begin
         hi_byte = b;
         hi_valid = 1'b1;
      end else begin
         c = '0;
         c.lanes[7:0] = b;
         c.count = lzbd_pkg::COUNT_W'(1);
         c.last = 1'b1;
         chunk_q.push_back(c);
         push_hist(b);
         flags = flags >> 1;
      end
   endfunction

   chunk_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         flags = lzbd_pkg::FLAG_EMPTY;
         hi_valid = 1'b0;
         hi_byte = '0;
         wr_ptr = '0;
         produced = 0;
         chunk_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) decode_request(req_in_byte, req_block_start);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_lane_bytes_24_31, rsp_lane_bytes_16_23, rsp_lane_bytes_8_15,
                   rsp_lane_bytes_0_7, rsp_byte_count, rsp_last_of_run,
                   rsp_bad_reference};
            if (chunk_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("ERROR: unexpected response %h", got);
            end else begin
               want = chunk_q.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("ERROR: response mismatch");
                     $display("  lanes exp %h got %h", want.lanes, got.lanes);
                     $display("  count exp %0d got %0d last exp %b got %b bad exp %b got %b",
                              want.count, got.count, want.last, got.last,
                              want.bad, got.bad);
                  end
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset;
   logic        req_valid, req_stall, req_block_start;
   logic [7:0]  req_in_byte;
   logic        rsp_valid, rsp_stall;
   logic [63:0] l0, l1, l2, l3;
   logic [5:0]  rsp_byte_count;
   logic        rsp_last_of_run, rsp_bad_reference;
   int          fail_count, pending_count;
   int          send_idle_pct, recv_idle_pct;

   lz_backref_decompressor_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_byte(req_in_byte), .req_block_start(req_block_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_lane_bytes_0_7(l0), .rsp_lane_bytes_8_15(l1),
      .rsp_lane_bytes_16_23(l2), .rsp_lane_bytes_24_31(l3),
      .rsp_byte_count(rsp_byte_count), .rsp_last_of_run(rsp_last_of_run),
      .rsp_bad_reference(rsp_bad_reference)
   );

   lzbd_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_byte(req_in_byte), .req_block_start(req_block_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_lane_bytes_0_7(l0), .rsp_lane_bytes_8_15(l1),
      .rsp_lane_bytes_16_23(l2), .rsp_lane_bytes_24_31(l3),
      .rsp_byte_count(rsp_byte_count), .rsp_last_of_run(rsp_last_of_run),
      .rsp_bad_reference(rsp_bad_reference),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Send one request and hold it until it is taken. Valid stays high after
   // the request is taken so that back-to-back requests need no gap.
   task automatic send_byte(logic [7:0] b, logic blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_block_start <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // A well-formed group: a flag byte and eight tokens. Short references
   // keep the copy length low; long ones stay rare.
   task automatic send_group(logic blk);
      logic [7:0] fl;
      logic [15:0] v;
      fl = 8'($urandom);
      send_byte(fl, blk);
      for (int t = 0; t < 8; t++) begin
         if (fl[t]) begin
            v = 16'($urandom);
            if (v[15] && $urandom_range(9) != 0) v[14:10] = '0;
            send_byte(v[15:8], 1'b0);
            send_byte(v[7:0], 1'b0);
         end else begin
            send_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   task automatic drain_wait();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (pending_count != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_in_byte = '0;
      req_block_start = 1'b0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: literals of extreme bytes, a bad reference, short and long
      // overlapping copies, then a block start during a half-read reference.
      send_byte(8'b1111_1100, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h5a, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);

      // Hold off until every response is back.
      drain_wait();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 57 : 0;
         recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 28 : 0;
         for (int g = 0; g < 3; g++) begin
            send_group(g == 0 && ph != 1);
            if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'($urandom_range(1)));
         end
      end
      send_idle_pct = 0;

      drain_wait();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule

`default_nettype wire
